@@ rtl/cle_pkg.sv @@
// ---------------------------------------------------------------------------
// cle_pkg: shared types and constants for the console line editor
// Byte codes, result kinds, escape states, controller states and the
// command/status structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
package cle_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int SEQ_CNT_W  = 2;

    localparam logic [BYTE_W-1:0] CH_ESC    = 8'd27;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_LEFT   = 8'h44;
    localparam logic [BYTE_W-1:0] CH_RIGHT  = 8'h43;
    localparam logic [BYTE_W-1:0] CH_CTRL_C = 8'h03;
    localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] MASK_DEF  = 8'd42;

    localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd3;

    localparam logic [MODE_W-1:0] ECHO_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] ECHO_MASK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_CHAR = 1'd1;

    localparam logic [1:0] ESC_IDLE    = 2'd0;
    localparam logic [1:0] ESC_SEEN    = 2'd1;
    localparam logic [1:0] ESC_BRACKET = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT,
        ST_LINE_RD,
        ST_LINE_OUT,
        ST_LINE_END
    } state_t;

    typedef struct packed {
        logic take_in;
        logic exec;
        logic seq_emit;
        logic line_read;
        logic char_emit;
        logic end_emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_line;
        logic seq_none;
        logic seq_final;
        logic line_empty;
        logic line_final;
    } status_t;

endpackage

@@ rtl/cle_ctrl.sv @@
// ---------------------------------------------------------------------------
// cle_ctrl: sequencing controller
// Accepts one byte, runs the edit step, then emits the echo sequence, if
// any, or walks the line buffer out through the output register.
// ---------------------------------------------------------------------------
module cle_ctrl
    import cle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.is_line)
                begin
                    state_next = status.line_empty ? ST_LINE_END : ST_LINE_RD;
                end
                else if (status.seq_none)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.seq_emit = 1'b1;
                    if (status.seq_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LINE_RD:
            begin
                cmd.line_read = 1'b1;
                state_next    = ST_LINE_OUT;
            end
            ST_LINE_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.char_emit = 1'b1;
                    state_next    = status.line_final ? ST_LINE_END : ST_LINE_RD;
                end
            end
            ST_LINE_END:
            begin
                if (status.out_free)
                begin
                    cmd.end_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cle_datapath.sv @@
// ---------------------------------------------------------------------------
// cle_datapath: line buffer, edit state and output register
// Holds the line memory, length, cursor, escape parser, configuration
// registers, the pending echo sequence and the result register.
// ---------------------------------------------------------------------------
module cle_datapath
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    out_kind,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 last
);

    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LINE_DEPTH);

    logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [MODE_W-1:0] echo_mode_reg;
    logic [BYTE_W-1:0] mask_char_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic [LEN_W-1:0]  cursor_reg;
    logic [LEN_W-1:0]  cursor_next;
    logic [1:0]        esc_reg;
    logic [1:0]        esc_next;
    logic [LEN_W-1:0]  line_idx_reg;

    logic [BYTE_W-1:0]    seq0_reg;
    logic [BYTE_W-1:0]    seq1_reg;
    logic [BYTE_W-1:0]    seq2_reg;
    logic [KIND_W-1:0]    seq_kind_reg;
    logic [SEQ_CNT_W-1:0] seq_cnt_reg;
    logic [SEQ_CNT_W-1:0] seq_idx_reg;

    logic [BYTE_W-1:0]    seq0_next;
    logic [BYTE_W-1:0]    seq1_next;
    logic [BYTE_W-1:0]    seq2_next;
    logic [KIND_W-1:0]    seq_kind_next;
    logic [SEQ_CNT_W-1:0] seq_cnt_next;
    logic                 is_line;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [BYTE_W-1:0]    echo_val;
    logic [BYTE_W-1:0]    seq_sel;

    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    // edit step for the byte held in byte_reg
    always_comb
    begin
        esc_next      = esc_reg;
        cursor_next   = cursor_reg;
        length_next   = length_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        seq0_next     = '0;
        seq1_next     = '0;
        seq2_next     = '0;
        seq_kind_next = KIND_ECHO;
        seq_cnt_next  = '0;
        is_line       = 1'b0;
        echo_val      = (echo_mode_reg == ECHO_MASK) ? mask_char_reg : byte_reg;
        if (esc_reg == ESC_SEEN)
        begin
            esc_next = (byte_reg == CH_LBRACK) ? ESC_BRACKET : ESC_IDLE;
        end
        else if (esc_reg != ESC_IDLE)
        begin
            esc_next = ESC_IDLE;
            if (byte_reg == CH_LEFT && cursor_reg != '0)
            begin
                cursor_next  = cursor_reg - LEN_W'(1);
                seq0_next    = CH_ESC;
                seq1_next    = CH_LBRACK;
                seq2_next    = CH_LEFT;
                seq_cnt_next = SEQ_CNT_W'(3);
            end
            else if (byte_reg == CH_RIGHT && cursor_reg < length_reg)
            begin
                cursor_next  = cursor_reg + LEN_W'(1);
                seq0_next    = CH_ESC;
                seq1_next    = CH_LBRACK;
                seq2_next    = CH_RIGHT;
                seq_cnt_next = SEQ_CNT_W'(3);
            end
        end
        else if (byte_reg == CH_BS)
        begin
            if (cursor_reg != '0)
            begin
                cursor_next = cursor_reg - LEN_W'(1);
                length_next = cursor_reg - LEN_W'(1);
                if (echo_mode_reg == ECHO_OFF)
                begin
                    seq0_next    = CH_SPACE;
                    seq1_next    = CH_BS;
                    seq_cnt_next = SEQ_CNT_W'(2);
                end
                else
                begin
                    seq0_next    = CH_BS;
                    seq1_next    = CH_SPACE;
                    seq2_next    = CH_BS;
                    seq_cnt_next = SEQ_CNT_W'(3);
                end
            end
            else
            begin
                seq0_next    = CH_ESC;
                seq1_next    = CH_LBRACK;
                seq2_next    = CH_RIGHT;
                seq_cnt_next = SEQ_CNT_W'(3);
            end
        end
        else if (byte_reg == CH_CTRL_C)
        begin
            seq_kind_next = KIND_ABORT;
            seq_cnt_next  = SEQ_CNT_W'(1);
            length_next   = '0;
            cursor_next   = '0;
        end
        else if (byte_reg == CH_LF)
        begin
            is_line = 1'b1;
        end
        else if (byte_reg != CH_CR)
        begin
            seq0_next = echo_val;
            if (echo_mode_reg != ECHO_OFF)
            begin
                seq_cnt_next = SEQ_CNT_W'(1);
            end
            if (byte_reg == CH_ESC)
            begin
                esc_next = ESC_SEEN;
            end
            else if (cursor_reg < length_reg)
            begin
                wr_en       = 1'b1;
                wr_addr     = cursor_reg[ADDR_W-1:0];
                cursor_next = cursor_reg + LEN_W'(1);
            end
            else if (length_reg < LEN_W'(LINE_DEPTH))
            begin
                wr_en       = 1'b1;
                wr_addr     = length_reg[ADDR_W-1:0];
                length_next = length_reg + LEN_W'(1);
                cursor_next = length_reg + LEN_W'(1);
            end
            else
            begin
                seq_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            line_mem[wr_addr] <= byte_reg;
        end
        if (cmd.line_read)
        begin
            rdata_reg <= line_mem[line_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_mode_reg <= ECHO_OFF;
            mask_char_reg <= MASK_DEF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ECHO_MODE: echo_mode_reg <= cfg_wdata[MODE_W-1:0];
                CFG_MASK_CHAR: mask_char_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            byte_reg <= rx_byte;
        end
        if (cmd.exec)
        begin
            seq0_reg     <= seq0_next;
            seq1_reg     <= seq1_next;
            seq2_reg     <= seq2_next;
            seq_kind_reg <= seq_kind_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            cursor_reg   <= '0;
            esc_reg      <= ESC_IDLE;
            line_idx_reg <= '0;
            seq_cnt_reg  <= '0;
            seq_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                length_reg   <= length_next;
                cursor_reg   <= cursor_next;
                esc_reg      <= esc_next;
                seq_cnt_reg  <= seq_cnt_next;
                seq_idx_reg  <= '0;
                line_idx_reg <= '0;
            end
            if (cmd.seq_emit)
            begin
                seq_idx_reg <= seq_idx_reg + SEQ_CNT_W'(1);
            end
            if (cmd.char_emit)
            begin
                line_idx_reg <= line_idx_reg + LEN_W'(1);
            end
            if (cmd.end_emit)
            begin
                length_reg <= '0;
                cursor_reg <= '0;
            end
        end
    end

    always_comb
    begin
        case (seq_idx_reg)
            2'd0:    seq_sel = seq0_reg;
            2'd1:    seq_sel = seq1_reg;
            default: seq_sel = seq2_reg;
        endcase
    end

    // result register: loads whenever empty or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.seq_emit || cmd.char_emit || cmd.end_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seq_emit)
        begin
            out_kind_reg <= seq_kind_reg;
            out_byte_reg <= seq_sel;
            out_last_reg <= status.seq_final;
        end
        else if (cmd.char_emit)
        begin
            out_kind_reg <= KIND_CHAR;
            out_byte_reg <= rdata_reg;
            out_last_reg <= 1'b0;
        end
        else if (cmd.end_emit)
        begin
            out_kind_reg <= KIND_END;
            out_byte_reg <= '0;
            out_last_reg <= 1'b1;
        end
    end

    always_comb
    begin
        status.out_free   = !out_valid_reg || out_ready;
        status.is_line    = is_line;
        status.seq_none   = (seq_cnt_next == '0);
        status.seq_final  = ((seq_idx_reg + SEQ_CNT_W'(1)) == seq_cnt_reg);
        status.line_empty = (length_reg == '0);
        status.line_final = ((line_idx_reg + LEN_W'(1)) == length_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;

`ifndef SYNTHESIS
    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= length_reg)
        else $error("cursor beyond line length");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(LINE_DEPTH))
        else $error("line length beyond buffer depth");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.seq_emit || cmd.char_emit || cmd.end_emit) |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_emit_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.seq_emit, cmd.char_emit, cmd.end_emit, cmd.exec}))
        else $error("conflicting datapath commands");
`endif

endmodule

@@ rtl/console_line_editor.sv @@
// ---------------------------------------------------------------------------
// console_line_editor: terminal line editor
// Takes received bytes one at a time and produces echo bytes, line
// characters, line-end and abort markers.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries rx_byte. A byte is taken only
//   while the editor is idle; each transfer is followed by the edit step.
//   Output channel out_valid/out_ready carries out_kind, out_byte and last;
//   last marks the final result of an input byte.
//   Each byte first runs the edit step; its results are then loaded into
//   the output register one after another. A newline instead walks the line
//   memory, with a registered memory read and then a load for each stored
//   character, and ends with the line-end marker.
//   A stalled receiver holds the output register; the sequencer waits and
//   no new input byte is taken until all results of the current one are
//   loaded. The next byte may be taken while the last result still waits.
//   Configuration (cfg_we, cfg_index, cfg_wdata) writes echo mode (index 0)
//   and mask character (index 1).
//   Reset clears length, cursor and escape state, sets echo mode 0 and the
//   mask character to '*'. The line memory is not cleared.
// ---------------------------------------------------------------------------
module console_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    out_kind,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cle_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule
